// ===== hw/rtl/range_add_assign_sum_store_core_macros.svh =====
// Assertion macros for the range store core checker.
`ifndef RANGE_ADD_ASSIGN_SUM_STORE_CORE_MACROS_SVH
`define RANGE_ADD_ASSIGN_SUM_STORE_CORE_MACROS_SVH
// Implication checked every cycle outside reset.
`define RAS_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("same-cycle check failed");
// Next-cycle implication checked outside reset.
`define RAS_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");
`endif

// ===== hw/rtl/ras_pkg.sv =====
// Shared types and constants for the range store core.
package ras_pkg;
  localparam int MaxElements = 1024;
  localparam int SizeW = 11;
  localparam int ValW = 64;
  localparam int OpndW = 32;
  localparam logic [10:0] ResetSize = 11'd1024;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_ASSIGN = 2'd1,
    OP_QUERY = 2'd2,
    OP_REBUILD = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    REG_ACTIVE_SIZE = 1'b0,
    REG_INITIAL_VALUE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic step;
    logic acc_clr;
    logic wr;
  } ras_cmd_t;

  typedef struct packed {
    logic last;
    logic is_query;
    logic is_rebuild;
    logic bad;
  } ras_sts_t;
endpackage

// ===== hw/rtl/ras_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module ras_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/ras_ctrl.sv =====
// Controller: sequences read, modify and write over one range.
module ras_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic                out_fire,
  input  ras_pkg::ras_sts_t   sts,
  output ras_pkg::ras_cmd_t   cmd,
  output logic                busy,
  output logic                out_pending
);
  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_READ, S_WAIT, S_WRITE, S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.load = in_fire;
        if (in_fire) state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.acc_clr = 1'b1;
        if (sts.bad) state_next = sts.is_query ? S_OUT : S_IDLE;
        else if (sts.is_rebuild) state_next = S_WRITE;
        else state_next = S_WAIT;
      end
      S_READ: begin
        state_next = S_WAIT;
      end
      S_WAIT: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.wr = 1'b1;
        cmd.step = 1'b1;
        if (sts.last) state_next = sts.is_query ? S_OUT : S_IDLE;
        else if (sts.is_rebuild) state_next = S_WRITE;
        else state_next = S_READ;
      end
      S_OUT: begin
        if (out_fire) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory clear after reset runs as a rebuild
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CHECK;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign out_pending = (state == S_OUT);
endmodule

// ===== hw/rtl/ras_dp.sv =====
// Datapath: item registers, index counter, accumulator and element memory.
module ras_dp #(
  parameter int MAX_ELEMENTS = ras_pkg::MaxElements
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ras_pkg::ras_cmd_t        cmd,
  input  logic [1:0]               operation,
  input  logic [10:0]              range_low,
  input  logic [10:0]              range_high,
  input  logic signed [31:0]       operand_value,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [63:0]              cfg_data,
  output ras_pkg::ras_sts_t        sts,
  output logic signed [63:0]       range_sum,
  output logic                     range_error
);
  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int IW = $clog2(MAX_ELEMENTS + 1);
  localparam int CW = (IW > 11) ? IW : 11;

  logic [10:0] active_size;
  logic [63:0] initial_value;
  ras_pkg::op_t op;
  logic [CW-1:0] lo, hi, idx;
  logic [63:0] val, acc, rdata, wdata;
  logic [CW-1:0] size_ext;
  logic [CW-1:0] raw_w;

  assign raw_w = CW'(cfg_data[10:0]);
  assign size_ext = CW'(active_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_size <= (CW'(ras_pkg::ResetSize) > CW'(MAX_ELEMENTS)) ?
                     11'(MAX_ELEMENTS) : ras_pkg::ResetSize;
      initial_value <= '0;
    end else if (cfg_we) begin
      if (cfg_index == ras_pkg::REG_ACTIVE_SIZE) begin
        active_size <= (raw_w > CW'(MAX_ELEMENTS)) ? 11'(MAX_ELEMENTS) : cfg_data[10:0];
      end else begin
        initial_value <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op <= ras_pkg::OP_REBUILD;
    end else if (cmd.load) begin
      op <= ras_pkg::op_t'(operation);
      lo <= CW'(range_low);
      hi <= CW'(range_high);
      val <= {{32{operand_value[31]}}, operand_value};
    end
    if (cmd.acc_clr) begin
      idx <= (op == ras_pkg::OP_REBUILD) ? CW'(1) : lo;
      acc <= '0;
    end else if (cmd.step) begin
      idx <= idx + CW'(1);
      acc <= acc + rdata;
    end
  end

  always_comb begin
    case (op)
      ras_pkg::OP_ADD: wdata = rdata + val;
      ras_pkg::OP_ASSIGN: wdata = val;
      ras_pkg::OP_QUERY: wdata = rdata;
      default: wdata = (idx <= size_ext) ? initial_value : 64'd0;
    endcase
  end

  ras_ram #(.WIDTH(64), .DEPTH(MAX_ELEMENTS)) u_ram (
    .clk(clk),
    .we(cmd.wr),
    .waddr(AW'(idx - CW'(1))),
    .wdata(wdata),
    .raddr(AW'(idx - CW'(1))),
    .rdata(rdata)
  );

  assign sts.is_query = (op == ras_pkg::OP_QUERY);
  assign sts.is_rebuild = (op == ras_pkg::OP_REBUILD);
  assign sts.bad = !sts.is_rebuild &&
                   ((lo == '0) || (lo > hi) || (hi > size_ext));
  assign sts.last = sts.is_rebuild ? (idx == CW'(MAX_ELEMENTS)) : (idx == hi);

  assign range_sum = acc;
  assign range_error = sts.bad;
endmodule

// ===== hw/rtl/range_add_assign_sum_store_core.sv =====
// Range add / assign / sum store over an element memory.
// One item at a time; s_tready is high only while the core is idle. After reset
// the core clears the memory before its first transfer: a setup step, then
// one write per memory element. After an input transfer, an add, assign or
// query on a valid range steps through read, registered data and write back
// for each element of its range; an invalid range ends at the range check;
// a rebuild takes the check step plus one write per memory element. Queries
// give one result, held on the master side until taken; other operations
// give none.
module range_add_assign_sum_store_core #(
  parameter int MAX_ELEMENTS = ras_pkg::MaxElements
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // operation[1:0], range_low[12:2], range_high[23:13], operand_value[55:24]
  input  logic [55:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // range_sum[63:0]
  output logic [63:0] m_tdata,
  // range_error
  output logic        m_tuser,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);
  ras_pkg::ras_cmd_t cmd;
  ras_pkg::ras_sts_t sts;
  logic busy;
  logic pend;

  assign s_tready = !busy;
  assign m_tvalid = pend;

  ras_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_fire(s_tvalid && s_tready),
    .out_fire(m_tvalid && m_tready),
    .sts(sts), .cmd(cmd), .busy(busy), .out_pending(pend)
  );

  ras_dp #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .operation(s_tdata[1:0]),
    .range_low(s_tdata[12:2]),
    .range_high(s_tdata[23:13]),
    .operand_value(s_tdata[55:24]),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sts(sts), .range_sum(m_tdata), .range_error(m_tuser)
  );
endmodule

// ===== hw/rtl/ras_checker.sv =====
// Port-level checker for the range store core, with its bind.
`include "range_add_assign_sum_store_core_macros.svh"
module ras_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser
);
  `RAS_ASSERT_IMP(err_sum_zero, clk, rst, m_tvalid && m_tuser, m_tdata == 64'd0)
  `RAS_ASSERT_IMP(no_in_while_out, clk, rst, m_tvalid, !s_tready)
  `RAS_ASSERT_NXT(busy_after_in, clk, rst, s_tvalid && s_tready, !s_tready)
  `RAS_ASSERT_NXT(out_holds, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind range_add_assign_sum_store_core ras_checker u_ras_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

// ===== tb/sv/testbench.sv =====
// Testbench for the range add / assign / sum store core.
`timescale 1ns / 1ps

module testbench;
  typedef struct {
    ras_pkg::op_t op;
    logic [10:0]  lo;
    logic [10:0]  hi;
    logic [31:0]  val;
  } range_op_t;

  typedef struct {
    logic [63:0] sum;
    logic        err;
  } sum_result_t;

  localparam int DRAIN_CYCLES = 3200;
  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_data;

  range_op_t   pending_ops[$];
  sum_result_t expected_sums[$];
  logic [63:0] elem_mem[1:1024];
  int          store_size;
  logic [63:0] fill_value;
  int          idle_pct;
  int          errors;
  int          stall_cycles;

  range_add_assign_sum_store_core DUT (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic bit range_valid(logic [10:0] lo, logic [10:0] hi);
    return lo >= 1 && lo <= hi && hi <= store_size;
  endfunction

  // Update the element store and queue any sum a query produces.
  function automatic void apply_range_op(range_op_t it);
    logic [63:0] sum;
    logic [63:0] v;
    sum = '0;
    v = {{32{it.val[31]}}, it.val};
    if (it.op == ras_pkg::OP_REBUILD) begin
      for (int i = 1; i <= 1024; i++) elem_mem[i] = (i <= store_size) ? fill_value : '0;
    end else if (it.op == ras_pkg::OP_QUERY) begin
      if (range_valid(it.lo, it.hi)) begin
        for (int i = it.lo; i <= it.hi; i++) sum += elem_mem[i];
        expected_sums.push_back('{sum, 1'b0});
      end else begin
        expected_sums.push_back('{64'd0, 1'b1});
      end
    end else if (range_valid(it.lo, it.hi)) begin
      for (int i = it.lo; i <= it.hi; i++)
        elem_mem[i] = (it.op == ras_pkg::OP_ADD) ? elem_mem[i] + v : v;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        apply_range_op(pending_ops[0]);
        void'(pending_ops.pop_front());
      end
      if (pending_ops.size() > 0 && $urandom_range(99) >= idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= {pending_ops[0].val, pending_ops[0].hi, pending_ops[0].lo,
                    pending_ops[0].op};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= $urandom_range(99) >= idle_pct;
      if (m_tvalid && m_tready) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: unexpected result sum=%h err=%b", $time, m_tdata, m_tuser);
          errors++;
        end else begin
          if (m_tdata !== expected_sums[0].sum) begin
            $display("%0t: range_sum expected %h actual %h", $time,
                     expected_sums[0].sum, m_tdata);
            errors++;
          end
          if (m_tuser !== expected_sums[0].err) begin
            $display("%0t: range_error expected %b actual %b", $time,
                     expected_sums[0].err, m_tuser);
            errors++;
          end
          void'(expected_sums.pop_front());
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(ras_pkg::reg_idx_t idx, logic [63:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ras_pkg::REG_ACTIVE_SIZE) store_size = (data[10:0] > 1024) ? 1024 : data[10:0];
    else fill_value = data;
  endtask

  task automatic drain_all();
    while (pending_ops.size() != 0 || expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_op(ras_pkg::op_t op, int lo, int hi, logic [31:0] val);
    pending_ops.push_back('{op, lo[10:0], hi[10:0], val});
  endtask

  task automatic push_random_op();
    ras_pkg::op_t op;
    int           lo;
    int           hi;
    int           pick;
    logic [31:0]  val;
    pick = $urandom_range(99);
    op = (pick < 4) ? ras_pkg::OP_REBUILD : (pick < 40) ? ras_pkg::OP_QUERY :
         (pick < 72) ? ras_pkg::OP_ADD : ras_pkg::OP_ASSIGN;
    val = $urandom();
    if ($urandom_range(9) == 0) val = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
    pick = $urandom_range(99);
    if (pick < 15 || store_size == 0) begin
      lo = $urandom_range(2047);
      hi = $urandom_range(2047);
    end else if (pick < 20) begin
      lo = 1;
      hi = store_size;
    end else begin
      lo = $urandom_range(store_size, 1);
      hi = lo + $urandom_range(7);
      if (hi > store_size) hi = store_size;
    end
    push_op(op, lo, hi, val);
  endtask

  initial begin
    logic [10:0] sizes[9];
    logic [63:0] fills[9];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = ras_pkg::REG_ACTIVE_SIZE;
    cfg_data = '0;
    errors = 0;
    idle_pct = 18;
    store_size = 1024;
    fill_value = '0;
    for (int i = 1; i <= 1024; i++) elem_mem[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every operation, invalid ranges, rebuild
    push_op(ras_pkg::OP_QUERY, 1, 1024, 0);
    push_op(ras_pkg::OP_ADD, 1, 1024, 32'h7fff_ffff);
    push_op(ras_pkg::OP_ADD, 1024, 1024, 32'h8000_0000);
    push_op(ras_pkg::OP_QUERY, 1, 1024, 0);
    push_op(ras_pkg::OP_ASSIGN, 5, 9, 32'h8000_0000);
    push_op(ras_pkg::OP_QUERY, 4, 10, 0);
    push_op(ras_pkg::OP_ADD, 0, 3, 32'h1);
    push_op(ras_pkg::OP_ASSIGN, 7, 6, 32'h5);
    push_op(ras_pkg::OP_ADD, 1, 1025, 32'h5);
    push_op(ras_pkg::OP_QUERY, 0, 5, 0);
    push_op(ras_pkg::OP_QUERY, 9, 8, 0);
    push_op(ras_pkg::OP_QUERY, 2047, 2047, 0);
    push_op(ras_pkg::OP_QUERY, 1, 2047, 0);
    push_op(ras_pkg::OP_REBUILD, 2047, 0, 32'hffff_ffff);
    push_op(ras_pkg::OP_QUERY, 1, 1024, 0);
    push_op(ras_pkg::OP_QUERY, 1024, 1024, 0);
    drain_all();

    sizes = '{11'd0, 11'd1, 11'd2047, 11'd1024, 11'd2, 11'd17, 11'd1024, 11'd33, 11'd1025};
    fills = '{64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, {$urandom(), $urandom()},
              64'hffff_ffff_ffff_ffff, 64'd0, {$urandom(), $urandom()},
              64'h0000_0001_0000_0000, {$urandom(), $urandom()}, 64'd3};
    for (int ph = 0; ph < 9; ph++) begin
      write_reg(ras_pkg::REG_ACTIVE_SIZE, {53'd0, sizes[ph]});
      write_reg(ras_pkg::REG_INITIAL_VALUE, fills[ph]);
      idle_pct = (ph == 3) ? 0 : 18;
      push_op(ras_pkg::OP_REBUILD, 0, 0, 0);
      for (int n = 0; n < 75; n++) push_random_op();
      push_op(ras_pkg::OP_QUERY, 1, store_size, 0);
      drain_all();
    end

    if (errors == 0 && expected_sums.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ras_pkg.sv
hw/rtl/ras_ram.sv
hw/rtl/ras_ctrl.sv
hw/rtl/ras_dp.sv
hw/rtl/range_add_assign_sum_store_core.sv
hw/rtl/ras_checker.sv
tb/sv/testbench.sv
